>>> sv/pfa_pkg.sv
package pfa_pkg;

    // Frame store geometry
    localparam int MaxPages = 4096;
    localparam int PageW    = $clog2(MaxPages);
    localparam int LinkW    = PageW + 1;
    localparam int CountW   = 16;
    localparam int TotalW   = 32;
    localparam int CfgW     = 13;
    localparam int CfgIdxW  = 3;

    // End-of-list marker: one past the last frame
    localparam logic [LinkW-1:0] Nil = LinkW'(MaxPages);

    // Stream payload widths
    localparam int InDataW  = 16;
    localparam int OutDataW = 64;

    typedef enum logic [1:0] {
        CMD_INIT    = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_ADD_REF = 2'd2,
        CMD_RELEASE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NO_FREE      = 2'd1,
        ST_OUT_OF_RANGE = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } t_status;

    typedef enum logic [CfgIdxW-1:0] {
        REG_PAGE_COUNT   = 3'd0,
        REG_LOW_FREE_END = 3'd1,
        REG_HOLE_START   = 3'd2,
        REG_HOLE_END     = 3'd3,
        REG_KERNEL_END   = 3'd4
    } t_reg_idx;

endpackage

>>> sv/page_frame_free_list_allocator.sv
// Page frame allocator with a LIFO free list and a reference count per frame.
// Input items arrive on the s_axis channel: tdata holds the command (init,
// allocate, add reference, release) and a page index. Every item gives one
// result item on the m_axis channel: status, frame, reference count after
// the operation, and the running number of successful allocations.
// The five limit registers are written through the cfg port; the user must
// write them only while the block is idle, which the block itself does not
// enforce. They take effect at the next init or range check.
// Allocate, add reference and release pass through a read step, in which the
// link, count and mark memories are read, and an update step, in which the
// registered read data is updated and written back.
// Init walks all 4096 frames from the top down, one memory write per cycle;
// the single write port of each memory sets that rate.
// One item is in work at a time. A finished result sits in an output
// register, so the next item is accepted while that result waits; if the
// receiver still stalls when the following result is ready, the block holds
// in its update step and writes nothing until the output register frees.
// Reset empties the free list and clears the allocation total; the memories
// are not cleared, and an init command must precede add reference or release.
module page_frame_free_list_allocator
    import pfa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // fields from bit 0: command[1:0], page_index[13:2], zero fill
    input  logic [InDataW-1:0]  s_axis_tdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // fields from bit 0: status[1:0], frame[13:2], count_now[29:14],
    // allocations_total[61:30], zero fill
    output logic [OutDataW-1:0] m_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic                i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgW-1:0]     i_cfg_wdata
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INIT = 4'b0010,
        S_READ = 4'b0100,
        S_EXEC = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CfgW-1:0]   r_page_count, r_low_free_end, r_hole_start, r_hole_end;
    logic [CfgW-1:0]   r_kernel_end;
    logic [LinkW-1:0]  r_head, n_head;
    logic [TotalW-1:0] r_alloc_cnt, n_alloc_cnt;
    t_cmd              r_cmd;
    logic [PageW-1:0]  r_addr;
    logic              r_oor;
    logic [PageW-1:0]  r_walk;
    logic              r_out_valid;
    logic [OutDataW-1:0] r_out_data, n_out_data;

    logic [CfgW-1:0]   eff_pages;
    logic              in_fire, out_free, load_out;
    t_cmd              in_cmd;
    logic [PageW-1:0]  in_page;
    logic [CfgW-1:0]   walk_ext;
    logic              walk_free;

    logic [LinkW-1:0]  link_rdata, link_wdata;
    logic [CountW-1:0] cnt_rdata, cnt_wdata;
    logic              mark_rdata, mark_wdata;
    logic              link_we, cnt_we, mark_we;
    logic [PageW-1:0]  waddr;

    t_status           res_status;
    logic [PageW-1:0]  res_frame;
    logic [CountW-1:0] res_count;
    logic [CountW-1:0] cnt_inc, cnt_dec;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count   <= CfgW'(MaxPages);
            r_low_free_end <= '0;
            r_hole_start   <= '0;
            r_hole_end     <= '0;
            r_kernel_end   <= CfgW'(MaxPages);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_PAGE_COUNT:   r_page_count   <= i_cfg_wdata;
                REG_LOW_FREE_END: r_low_free_end <= i_cfg_wdata;
                REG_HOLE_START:   r_hole_start   <= i_cfg_wdata;
                REG_HOLE_END:     r_hole_end     <= i_cfg_wdata;
                REG_KERNEL_END:   r_kernel_end   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Frames managed, clipped to the store depth
    assign eff_pages = (r_page_count > CfgW'(MaxPages)) ? CfgW'(MaxPages) : r_page_count;

    assign in_cmd   = t_cmd'(s_axis_tdata[1:0]);
    assign in_page  = s_axis_tdata[PageW+1:2];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign load_out = (r_state == S_EXEC) && out_free;

    // Free test for the frame under the init walk
    assign walk_ext  = {1'b0, r_walk};
    assign walk_free = (walk_ext < eff_pages) &&
                       ((walk_ext < r_low_free_end) ||
                        ((walk_ext >= r_hole_start) && (walk_ext < r_hole_end)) ||
                        (walk_ext >= r_kernel_end));

    // Saturating count steps
    assign cnt_inc = (cnt_rdata == {CountW{1'b1}}) ? cnt_rdata : cnt_rdata + 1'b1;
    assign cnt_dec = (cnt_rdata == '0) ? cnt_rdata : cnt_rdata - 1'b1;

    // Update step: result fields, memory writes and list head
    always_comb begin
        res_status  = ST_OK;
        res_frame   = '0;
        res_count   = '0;
        n_head      = r_head;
        n_alloc_cnt = r_alloc_cnt;
        link_we     = 1'b0;
        cnt_we      = 1'b0;
        mark_we     = 1'b0;
        link_wdata  = Nil;
        cnt_wdata   = '0;
        mark_wdata  = 1'b0;
        waddr       = r_addr;

        if (r_state == S_INIT) begin
            // Walking downward links the free frames in ascending order
            waddr      = r_walk;
            link_we    = 1'b1;
            cnt_we     = 1'b1;
            mark_we    = 1'b1;
            link_wdata = walk_free ? r_head : Nil;
            mark_wdata = walk_free;
            if (walk_free) begin
                n_head = {1'b0, r_walk};
            end
        end else if (r_state == S_EXEC) begin
            case (r_cmd)
                CMD_INIT: ;
                CMD_ALLOC: begin
                    if (r_head[PageW]) begin
                        res_status = ST_NO_FREE;
                    end else begin
                        res_frame   = r_addr;
                        res_count   = cnt_rdata;
                        n_alloc_cnt = r_alloc_cnt + 1'b1;
                        n_head      = link_rdata;
                        link_we     = 1'b1;
                        mark_we     = 1'b1;
                    end
                end
                CMD_ADD_REF: begin
                    res_frame = r_addr;
                    if (r_oor) begin
                        res_status = ST_OUT_OF_RANGE;
                    end else begin
                        res_count = cnt_inc;
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_inc;
                    end
                end
                CMD_RELEASE: begin
                    res_frame = r_addr;
                    if (r_oor) begin
                        res_status = ST_OUT_OF_RANGE;
                    end else if (mark_rdata) begin
                        res_status = ST_ALREADY_FREE;
                        res_count  = cnt_rdata;
                    end else begin
                        res_count = cnt_dec;
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_dec;
                        if (cnt_dec == '0) begin
                            // Count reached zero: push the frame back
                            link_we    = 1'b1;
                            link_wdata = r_head;
                            mark_we    = 1'b1;
                            mark_wdata = 1'b1;
                            n_head     = {1'b0, r_addr};
                        end
                    end
                end
                default: ;
            endcase
            // Nothing changes while the result cannot be placed
            if (!out_free) begin
                n_head      = r_head;
                n_alloc_cnt = r_alloc_cnt;
                link_we     = 1'b0;
                cnt_we      = 1'b0;
                mark_we     = 1'b0;
            end
        end
    end

    assign n_out_data = {{(OutDataW - 2 - PageW - CountW - TotalW){1'b0}},
                         n_alloc_cnt, res_count, res_frame, res_status};

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = (in_cmd == CMD_INIT) ? S_INIT : S_READ;
                end
            end
            S_INIT: begin
                if (r_walk == '0) begin
                    n_state = S_EXEC;
                end
            end
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= Nil;
            r_alloc_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= (in_fire && in_cmd == CMD_INIT) ? Nil : n_head;
            r_alloc_cnt <= n_alloc_cnt;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item registers and init walk counter
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd  <= in_cmd;
            r_addr <= (in_cmd == CMD_ALLOC) ? r_head[PageW-1:0] : in_page;
            r_oor  <= ({1'b0, in_page} >= eff_pages);
            r_walk <= PageW'(MaxPages - 1);
        end else if (r_state == S_INIT) begin
            r_walk <= r_walk - 1'b1;
        end
        if (load_out) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Link, count and free-mark memories
    pfa_ram #(.WIDTH(LinkW), .DEPTH(MaxPages)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (waddr),
        .i_wdata (link_wdata),
        .i_raddr (r_addr),
        .o_rdata (link_rdata)
    );

    pfa_ram #(.WIDTH(CountW), .DEPTH(MaxPages)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (waddr),
        .i_wdata (cnt_wdata),
        .i_raddr (r_addr),
        .o_rdata (cnt_rdata)
    );

    pfa_ram #(.WIDTH(1), .DEPTH(MaxPages)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (waddr),
        .i_wdata (mark_wdata),
        .i_raddr (r_addr),
        .o_rdata (mark_rdata)
    );

`ifndef NO_ASSERTIONS
    // The list head is either a frame number or exactly the end marker
    a_head_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head[PageW] |-> (r_head[PageW-1:0] == '0))
        else $error("list head holds an illegal value");

    // The allocation total moves only with a successful allocate
    a_total_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_alloc_cnt != $past(r_alloc_cnt)) |->
            (!$past(i_rst_n) ||
             ($past(load_out) && $past(r_cmd) == CMD_ALLOC && !$past(r_head[PageW]))))
        else $error("allocation total changed without an allocation");

    // No memory is written while a stalled result waits for the output slot
    a_no_write_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && !out_free) |-> !(link_we || cnt_we || mark_we))
        else $error("memory written while the result is held");

    // A finished allocate from an empty list leaves the head at the end marker
    a_empty_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load_out && r_cmd == CMD_ALLOC && r_head[PageW]) |=> r_head[PageW])
        else $error("empty list changed on a failed allocation");
`endif

endmodule

>>> sv/pfa_ram.sv
module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
